/* hw/rtl/sha1_message_digest_macros.svh */
// Assertion helpers for the SHA-1 digest checker.
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SHA1MD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha1md check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha1md check failed");

`endif

/* hw/rtl/sha1md_pkg.sv */
`timescale 1ns / 1ps
package sha1md_pkg;

  localparam logic [4:0][31:0] IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] PAD_BYTE = 32'h80000000;

  localparam int ROUNDS      = 80;
  localparam int BLOCK_WORDS = 16;
  localparam int LEN_HI_POS  = 14;
  localparam int DIGEST_LAST = 4;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [31:0] data;
    logic        final_blk;
  } blk_word_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

endpackage

/* hw/rtl/sha1md_ifs.sv */
`timescale 1ns / 1ps
interface sha1md_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  byte_count;
  logic        is_last;

  modport source(output valid, message_word, byte_count, is_last, input ready);
  modport sink(input valid, message_word, byte_count, is_last, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

/* hw/rtl/sha1md_front.sv */
`timescale 1ns / 1ps
module sha1md_front (
  input  logic                  clk,
  input  logic                  rst,
  sha1md_in_if.sink             msg,
  output logic                  push_valid,
  input  logic                  push_ready,
  output sha1md_pkg::blk_word_t push_data
);
  import sha1md_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_PAD, F_ZERO, F_LENHI, F_LENLO} fstate_t;

  fstate_t     state;
  logic [31:0] acc;
  logic [1:0]  acc_n;
  logic [3:0]  wpos;
  logic [63:0] bit_length;

  logic [2:0]  cnt;
  logic [31:0] mask;
  logic [31:0] mw;
  logic [63:0] comb;
  logic [2:0]  total;
  logic        take;
  logic        pushed;

  assign cnt   = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;
  assign mw    = msg.message_word & mask;
  assign comb  = {acc, 32'h0} | ({mw, 32'h0} >> {acc_n, 3'b000});
  assign total = {1'b0, acc_n} + cnt;

  assign msg.ready = (state == F_IDLE) && push_ready;
  assign take      = msg.valid && msg.ready;
  assign pushed    = push_valid && push_ready;

  always_comb begin
    unique case (cnt)
      3'd0:    mask = 32'h00000000;
      3'd1:    mask = 32'hFF000000;
      3'd2:    mask = 32'hFFFF0000;
      3'd3:    mask = 32'hFFFFFF00;
      default: mask = 32'hFFFFFFFF;
    endcase
  end

  always_comb begin
    push_data.final_blk = 1'b0;
    unique case (state)
      F_IDLE: begin
        push_valid     = msg.valid && total[2];
        push_data.data = comb[63:32];
      end
      F_PAD: begin
        push_valid     = 1'b1;
        push_data.data = acc | (PAD_BYTE >> {acc_n, 3'b000});
      end
      F_ZERO: begin
        push_valid     = 1'b1;
        push_data.data = 32'h0;
      end
      F_LENHI: begin
        push_valid     = 1'b1;
        push_data.data = bit_length[63:32];
      end
      F_LENLO: begin
        push_valid          = 1'b1;
        push_data.data      = bit_length[31:0];
        push_data.final_blk = 1'b1;
      end
      default: begin
        push_valid     = 1'b0;
        push_data.data = 32'h0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      acc        <= 32'h0;
      acc_n      <= 2'd0;
      wpos       <= 4'd0;
      bit_length <= 64'd0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (take) begin
            bit_length <= bit_length + {58'd0, cnt, 3'b000};
            acc_n      <= total[1:0];
            if (total[2]) begin
              acc  <= comb[31:0];
              wpos <= wpos + 4'd1;
            end else begin
              acc <= comb[63:32];
            end
            if (msg.is_last) state <= F_PAD;
          end
        end
        F_PAD, F_ZERO: begin
          if (pushed) begin
            acc   <= 32'h0;
            acc_n <= 2'd0;
            wpos  <= wpos + 4'd1;
            state <= (wpos + 4'd1 == 4'(LEN_HI_POS)) ? F_LENHI : F_ZERO;
          end
        end
        F_LENHI: begin
          if (pushed) begin
            wpos  <= wpos + 4'd1;
            state <= F_LENLO;
          end
        end
        F_LENLO: begin
          if (pushed) begin
            wpos       <= 4'd0;
            bit_length <= 64'd0;
            state      <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/sha1md_queue.sv */
`timescale 1ns / 1ps
module sha1md_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  sha1md_pkg::blk_word_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output sha1md_pkg::blk_word_t pop_data
);
  import sha1md_pkg::*;

  blk_word_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != (QPTR_W+1)'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/sha1md_back.sv */
`timescale 1ns / 1ps
module sha1md_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  sha1md_pkg::blk_word_t pop_data,
  sha1md_out_if.source          digest
);
  import sha1md_pkg::*;

  typedef enum logic [1:0] {B_LOAD, B_ROUND, B_ADD, B_OUT} bstate_t;

  bstate_t           state;
  logic [4:0][31:0]  chain;
  logic [4:0][31:0]  vars;
  logic [15:0][31:0] sched;
  logic [3:0]        cnt;
  logic [6:0]        rnd;
  logic              final_blk;
  logic [2:0]        out_idx;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;
  logic [31:0] wnew;

  always_comb begin
    priority if (rnd < 7'd20) begin
      f = (vars[1] & vars[2]) | (~vars[1] & vars[3]);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = vars[1] ^ vars[2] ^ vars[3];
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (vars[1] & vars[2]) | (vars[1] & vars[3]) | (vars[2] & vars[3]);
      k = K2;
    end else begin
      f = vars[1] ^ vars[2] ^ vars[3];
      k = K3;
    end
  end

  assign t    = rotl(vars[0], 5) + f + vars[4] + k + sched[0];
  assign wnew = rotl(sched[13] ^ sched[8] ^ sched[2] ^ sched[0], 1);

  assign pop_ready          = state == B_LOAD;
  assign digest.valid       = state == B_OUT;
  assign digest.digest_word = chain[out_idx];
  assign digest.word_index  = out_idx;
  assign digest.last_word   = out_idx == 3'(DIGEST_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_LOAD;
      chain     <= IV;
      vars      <= '0;
      cnt       <= 4'd0;
      rnd       <= 7'd0;
      final_blk <= 1'b0;
      out_idx   <= 3'd0;
    end else begin
      unique case (state)
        B_LOAD: begin
          if (pop_valid) begin
            sched     <= {pop_data.data, sched[15:1]};
            final_blk <= pop_data.final_blk;
            cnt       <= cnt + 4'd1;
            if (cnt == 4'(BLOCK_WORDS - 1)) begin
              vars  <= chain;
              rnd   <= 7'd0;
              state <= B_ROUND;
            end
          end
        end
        B_ROUND: begin
          vars  <= {vars[3], vars[2], rotl(vars[1], 30), vars[0], t};
          sched <= {wnew, sched[15:1]};
          rnd   <= rnd + 7'd1;
          if (rnd == 7'(ROUNDS - 1)) state <= B_ADD;
        end
        B_ADD: begin
          for (int i = 0; i < 5; i++) chain[i] <= chain[i] + vars[i];
          state <= final_blk ? B_OUT : B_LOAD;
        end
        B_OUT: begin
          if (digest.ready) begin
            if (out_idx == 3'(DIGEST_LAST)) begin
              chain   <= IV;
              out_idx <= 3'd0;
              state   <= B_LOAD;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: state <= B_LOAD;
      endcase
    end
  end

endmodule

/* hw/rtl/sha1_message_digest.sv */
`timescale 1ns / 1ps
// Channel  Modport  Payload                                  Transfer
// msg      sink     message_word[32] byte_count[3] is_last   valid & ready
// digest   source   digest_word[32] word_index[3] last_word  valid & ready
//
// Front packs bytes into block words, one item per cycle while idle and the 4-word queue
// has room; after a last item it emits the padding and length words before taking more.
// Back loads 16 words then runs one SHA-1 round per cycle in the single round unit,
// taking no new words until the block is added and any digest has been sent.
// Digest: five back-to-back transfers after the final block, held while ready is low.
// Synchronous reset restores the initial chaining values; no clearing pass.
module sha1_message_digest (
  input  logic         clk,
  input  logic         rst,
  sha1md_in_if.sink    msg,
  sha1md_out_if.source digest
);
  import sha1md_pkg::*;

  blk_word_t push_data;
  blk_word_t pop_data;
  logic      push_valid;
  logic      push_ready;
  logic      pop_valid;
  logic      pop_ready;

  sha1md_front u_front (
    .clk        (clk),
    .rst        (rst),
    .msg        (msg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sha1md_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sha1md_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .digest    (digest)
  );

endmodule

/* hw/rtl/sha1md_checker.sv */
`timescale 1ns / 1ps
`include "sha1_message_digest_macros.svh"
module sha1md_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  `SHA1MD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(digest_word) && $stable(word_index))
  `SHA1MD_ASSERT_NEXT(a_burst, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 3'd1)
  `SHA1MD_ASSERT_NOW(a_last, out_valid, last_word == (word_index == 3'd4))
  `SHA1MD_ASSERT_NOW(a_range, out_valid, word_index <= 3'd4)
  `SHA1MD_ASSERT_NEXT(a_gap, out_valid && out_ready && last_word, !out_valid)

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (digest.valid),
  .out_ready   (digest.ready),
  .digest_word (digest.digest_word),
  .word_index  (digest.word_index),
  .last_word   (digest.last_word)
);

/* dv/sha1md_digest_check.sv */
`timescale 1ns / 1ps
module sha1md_digest_check (
  input  logic  clk,
  input  logic  rst,
  sha1md_in_if  msg,
  sha1md_out_if digest,
  output int    fail_count,
  output int    pending,
  output int    words_checked
);

  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };
  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_PA1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_PA2 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  localparam logic [5:0]  LEN_OFFSET = 6'd56;
  localparam int          MAX_BYTES = 4;
  localparam int          DIGEST_WORDS = 5;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_rec_t;

  digest_rec_t digest_q[$];

  logic [31:0] chain [5];
  logic [31:0] blk [16];
  logic [63:0] bit_len;
  logic [5:0]  fill;

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < DIGEST_WORDS; i++) chain[i] = H_INIT[i];
    bit_len = '0;
    fill = '0;
  endfunction

  function automatic void compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) w[r] = blk[r];
    for (int r = 16; r < 80; r++) w[r] = rol32(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_PA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = K_PA2;
      end
      t = rol32(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  function automatic void put_byte(input logic [7:0] v);
    int sh;
    sh = 24 - 8 * int'(fill[1:0]);
    if (fill[1:0] == 2'd0) blk[fill[5:2]] = '0;
    blk[fill[5:2]] |= 32'(v) << sh;
    if (fill == 6'd63) compress();
    fill = fill + 6'd1;
  endfunction

  function automatic void absorb_item(input logic [31:0] word, input logic [2:0] cnt,
                                      input logic last);
    int n;
    digest_rec_t rec;
    n = (int'(cnt) > MAX_BYTES) ? MAX_BYTES : int'(cnt);
    for (int i = 0; i < n; i++) begin
      put_byte(word[31 - 8 * i -: 8]);
      bit_len += 64'd8;
    end
    if (last) begin
      put_byte(PAD_MARK);
      while (fill != LEN_OFFSET) put_byte(8'h00);
      blk[14] = bit_len[63:32];
      blk[15] = bit_len[31:0];
      compress();
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        rec.digest_word = chain[i];
        rec.word_index  = 3'(i);
        rec.last_word   = (i == DIGEST_WORDS - 1);
        digest_q.push_back(rec);
      end
      restart_message();
    end
  endfunction

  always @(posedge clk) begin
    digest_rec_t want;
    if (rst) begin
      restart_message();
      digest_q.delete();
    end else begin
      if (msg.valid && msg.ready) absorb_item(msg.message_word, msg.byte_count, msg.is_last);
      if (digest.valid && digest.ready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest transfer: word %h index %0d", digest.digest_word,
                 digest.word_index);
          fail_count++;
        end else begin
          want = digest_q.pop_front();
          words_checked++;
          if (digest.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, actual %h", want.digest_word,
                   digest.digest_word);
            fail_count++;
          end
          if (digest.word_index !== want.word_index) begin
            $error("word_index: expected %0d, actual %0d", want.word_index,
                   digest.word_index);
            fail_count++;
          end
          if (digest.last_word !== want.last_word) begin
            $error("last_word: expected %0b, actual %0b", want.last_word, digest.last_word);
            fail_count++;
          end
        end
      end
    end
    pending = digest_q.size();
  end

endmodule

/* dv/sha1_message_digest_test.sv */
`timescale 1ns / 1ps
module sha1_message_digest_test;

  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 360;
  localparam int DRAIN_CYCLES   = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_count     = 0;
  int items_sent     = 0;
  int messages_sent  = 0;
  int directed_items = 0;
  int stall_cycles   = 0;

  int fail_count;
  int pending;
  int words_checked;

  sha1md_in_if  msg ();
  sha1md_out_if digest ();

  sha1_message_digest dut (
    .clk(clk),
    .rst(rst),
    .msg(msg),
    .digest(digest)
  );

  sha1md_digest_check digest_check (
    .clk(clk),
    .rst(rst),
    .msg(msg),
    .digest(digest),
    .fail_count(fail_count),
    .pending(pending),
    .words_checked(words_checked)
  );

  always #5 clk = ~clk;

  // long back-pressure once requested, random stalls otherwise
  always @(negedge clk) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      digest.ready = 1'b0;
      hold_count++;
    end else begin
      digest.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((msg.valid && msg.ready) || (digest.valid && digest.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL sha1_message_digest");
      $finish;
    end
  end

  task automatic send_item(input logic [31:0] word, input logic [2:0] cnt, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      msg.valid = 1'b0;
      @(negedge clk);
    end
    msg.valid        = 1'b1;
    msg.message_word = word;
    msg.byte_count   = cnt;
    msg.is_last      = last;
    do @(posedge clk); while (!msg.ready);
    @(negedge clk);
    items_sent++;
    if (last) messages_sent++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_message(input int n_words);
    logic [2:0] cnt;
    for (int i = 0; i < n_words; i++) begin
      if (i == n_words - 1) begin
        cnt = ($urandom_range(99) < 15) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        send_item(pick_word(), cnt, 1'b1);
      end else begin
        cnt = ($urandom_range(99) < 8) ? 3'($urandom_range(7)) : 3'd4;
        send_item(pick_word(), cnt, 1'b0);
      end
    end
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 10) return $urandom_range(2, 1);
    if (r < 75) return $urandom_range(20, 3);
    if (r < 95) return $urandom_range(40, 21);
    return $urandom_range(70, 41);
  endfunction

  initial begin
    int done;
    msg.valid        = 1'b0;
    msg.message_word = '0;
    msg.byte_count   = '0;
    msg.is_last      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty message, three-byte message with junk low byte
    send_item(32'h0000_0000, 3'd0, 1'b1);
    send_item(32'h6162_6364, 3'd3, 1'b1);
    // ragged words inside a message, oversized counts
    send_item(32'hAABB_CCDD, 3'd2, 1'b0);
    send_item(32'h1122_3344, 3'd1, 1'b0);
    send_item(32'hFFFF_FFFF, 3'd7, 1'b1);
    send_item(32'h0000_0000, 3'd5, 1'b0);
    send_item(32'h1234_5678, 3'd6, 1'b1);
    // 56 bytes: length no longer fits, needs an extra block
    for (int i = 0; i < 14; i++) send_item(32'hFFFF_FFFF, 3'd4, i == 13);
    send_item(32'hDEAD_BEEF, 3'd0, 1'b1);
    directed_items = items_sent;

    hold_req = 1'b1;
    send_message(30);
    send_message(12);
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      done = items_sent - directed_items;
      case (done * 4 / RANDOM_ITEMS)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 56;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 56;
        end
        default: begin
          src_idle_pct   = 28;
          sink_stall_pct = 28;
        end
      endcase
      send_message(pick_length());
    end
    msg.valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d messages in %0d items (%0d directed: empty, ragged, padding overflow),",
             messages_sent, items_sent, directed_items);
    $display("%0d digest words checked across idle, stall and back-pressure phases",
             words_checked);
    if (fail_count == 0) begin
      $display("PASS sha1_message_digest");
    end else begin
      $display("FAIL sha1_message_digest");
    end
    $finish;
  end

endmodule
